// ===== rtl/cmm_pkg.sv =====
// Shared constants and types of the centered moving-maximum filter.
package cmm_pkg;

	localparam int MAX_HALF    = 16;
	localparam int SAMPLE_BITS = 8;
	localparam int HALF_REG_W  = 5;
	localparam logic [HALF_REG_W-1:0] HALF_RESET = HALF_REG_W'(7);

	// Window line holds the center plus MAX_HALF samples on each side.
	localparam int DEPTH   = 2 * MAX_HALF + 1;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int NUM_LVL = $clog2(DEPTH);

	// A job carries up to MAX_HALF+1 results (one flush run).
	localparam int NUM_RES = MAX_HALF + 1;
	localparam int JW      = $clog2(NUM_RES);

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic          flush;
		logic [JW-1:0] j_first;
		logic [JW-1:0] half;
	} cmm_meta_t;

	typedef struct packed {
		logic [NUM_RES-1:0][SAMPLE_BITS-1:0] vals;
		logic [JW-1:0]                       j_first;
		logic                                flush;
	} cmm_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cmm_qstat_t;

endpackage

// ===== rtl/cmm_front.sv =====
// Front end: window line, line bookkeeping and registered prefix-maximum tree.
module cmm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [cmm_pkg::SAMPLE_BITS-1:0]      sample,
	input  logic                                 last_in,
	input  logic                                 win_half_we,
	input  logic [cmm_pkg::HALF_REG_W-1:0]       win_half,
	input  cmm_pkg::cmm_qstat_t                  q_stat,
	output logic                                 push,
	output cmm_pkg::cmm_job_t                    push_job
);

	logic [cmm_pkg::HALF_REG_W-1:0]  half_q;
	logic [cmm_pkg::SAMPLE_BITS-1:0] store_q [cmm_pkg::DEPTH];
	logic [cmm_pkg::CNT_W-1:0]       fill_q;
	logic [cmm_pkg::CNT_W-1:0]       fill_nxt;
	logic [cmm_pkg::CNT_W-1:0]       fill_m1;
	logic [cmm_pkg::JW-1:0]          h_eff;
	logic [cmm_pkg::JW-1:0]          start;
	logic                            en;
	logic                            accept;
	logic                            job_in;
	cmm_pkg::cmm_meta_t              meta_in;
	logic [cmm_pkg::IDX_W-1:0]       idx;

	logic [cmm_pkg::SAMPLE_BITS-1:0] snap    [cmm_pkg::DEPTH];
	logic [cmm_pkg::SAMPLE_BITS-1:0] lvl_in  [cmm_pkg::NUM_LVL][cmm_pkg::DEPTH];
	logic [cmm_pkg::SAMPLE_BITS-1:0] lvl_out [cmm_pkg::NUM_LVL][cmm_pkg::DEPTH];
	logic [cmm_pkg::SAMPLE_BITS-1:0] pfx_s   [cmm_pkg::NUM_LVL][cmm_pkg::DEPTH];
	cmm_pkg::cmm_meta_t              meta_s  [cmm_pkg::NUM_LVL];
	logic [cmm_pkg::NUM_LVL-1:0]     vld_s;

	// Whole tree advances together; it halts only when its tail cannot enter the queue.
	assign en       = !(vld_s[cmm_pkg::NUM_LVL-1] && q_stat.full);
	assign in_stall = !en;
	assign accept   = in_valid && en;
	assign push     = vld_s[cmm_pkg::NUM_LVL-1] && !q_stat.full;

	assign fill_nxt = (fill_q == cmm_pkg::CNT_W'(cmm_pkg::DEPTH)) ? fill_q : fill_q + 1'b1;
	assign fill_m1  = fill_nxt - 1'b1;

	always_comb begin
		if (32'(half_q) > 32'(cmm_pkg::MAX_HALF)) begin
			h_eff = cmm_pkg::JW'(cmm_pkg::MAX_HALF);
		end else begin
			h_eff = cmm_pkg::JW'(half_q);
		end
		if (32'(fill_m1) < 32'(h_eff)) begin
			start = cmm_pkg::JW'(fill_m1);
		end else begin
			start = h_eff;
		end
		meta_in.flush   = last_in;
		meta_in.half    = h_eff;
		meta_in.j_first = last_in ? start : h_eff;
		job_in          = accept && (last_in || (32'(fill_nxt) > 32'(h_eff)));
	end

	// Window as it stands after the shift; entries older than the line read as zero.
	assign snap[0] = sample;
	for (genvar k = 1; k < cmm_pkg::DEPTH; k++) begin : g_snap
		assign snap[k] = (cmm_pkg::CNT_W'(k) < fill_nxt) ? store_q[k-1] : '0;
	end

	// Prefix maximum, one doubling step per stage.
	for (genvar l = 0; l < cmm_pkg::NUM_LVL; l++) begin : g_lvl
		for (genvar k = 0; k < cmm_pkg::DEPTH; k++) begin : g_ent
			if (l == 0) begin : g_first
				assign lvl_in[l][k] = snap[k];
			end else begin : g_next
				assign lvl_in[l][k] = pfx_s[l-1][k];
			end
			if (k >= (1 << l)) begin : g_cmp
				assign lvl_out[l][k] = (lvl_in[l][k] > lvl_in[l][k-(1<<l)]) ?
					lvl_in[l][k] : lvl_in[l][k-(1<<l)];
			end else begin : g_pass
				assign lvl_out[l][k] = lvl_in[l][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= cmm_pkg::HALF_RESET;
			fill_q <= '0;
			vld_s  <= '0;
		end else begin
			if (win_half_we) begin
				half_q <= win_half;
			end
			if (accept) begin
				fill_q <= last_in ? '0 : fill_nxt;
			end
			if (en) begin
				vld_s <= {vld_s[cmm_pkg::NUM_LVL-2:0], job_in};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q[0] <= sample;
			for (int k = 1; k < cmm_pkg::DEPTH; k++) begin
				store_q[k] <= store_q[k-1];
			end
		end
		if (en) begin
			meta_s[0] <= meta_in;
			pfx_s[0]  <= lvl_out[0];
			for (int l = 1; l < cmm_pkg::NUM_LVL; l++) begin
				meta_s[l] <= meta_s[l-1];
				pfx_s[l]  <= lvl_out[l];
			end
		end
	end

	// Result j of a job is the prefix maximum ending at half + j.
	always_comb begin
		push_job.flush   = meta_s[cmm_pkg::NUM_LVL-1].flush;
		push_job.j_first = meta_s[cmm_pkg::NUM_LVL-1].j_first;
		idx              = '0;
		for (int j = 0; j < cmm_pkg::NUM_RES; j++) begin
			idx = cmm_pkg::IDX_W'(meta_s[cmm_pkg::NUM_LVL-1].half) + cmm_pkg::IDX_W'(j);
			push_job.vals[j] = pfx_s[cmm_pkg::NUM_LVL-1][idx];
		end
	end

endmodule

// ===== rtl/cmm_fifo.sv =====
// Two-entry job queue between the front end and the result sequencer.
module cmm_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cmm_pkg::cmm_job_t   push_job,
	input  logic                pop,
	output cmm_pkg::cmm_job_t   head_job,
	output cmm_pkg::cmm_qstat_t stat
);

	cmm_pkg::cmm_job_t          mem_q [cmm_pkg::Q_DEPTH];
	logic [cmm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [cmm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [cmm_pkg::QCNT_W-1:0] count_q;

	assign stat.full  = (count_q == cmm_pkg::QCNT_W'(cmm_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == cmm_pkg::QPTR_W'(cmm_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == cmm_pkg::QPTR_W'(cmm_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("job popped from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cmm_pkg::QCNT_W'(cmm_pkg::Q_DEPTH))
		else $error("queue occupancy out of range");

endmodule

// ===== rtl/cmm_back.sv =====
// Back end: walks each job's results into the output register.
module cmm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmm_pkg::cmm_qstat_t             q_stat,
	input  cmm_pkg::cmm_job_t               head_job,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cmm_pkg::SAMPLE_BITS-1:0] filtered_value,
	output logic                            last_out
);

	cmm_pkg::cmm_job_t               job_q;
	logic                            busy_q;
	logic [cmm_pkg::JW-1:0]          j_q;
	logic                            ov_q;
	logic [cmm_pkg::SAMPLE_BITS-1:0] val_q;
	logic                            last_q;
	logic                            out_free;
	logic                            produce;
	logic                            done;

	assign out_free = !ov_q || !out_stall;
	assign produce  = busy_q && out_free;
	// A plain job gives one result; a flush run counts down to index zero.
	assign done     = !job_q.flush || (j_q == '0);
	assign pop      = !q_stat.empty && (!busy_q || (produce && done));

	assign out_valid      = ov_q;
	assign filtered_value = val_q;
	assign last_out       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (produce && done) begin
				busy_q <= 1'b0;
			end
			if (produce) begin
				ov_q <= 1'b1;
			end else if (out_free) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
			j_q   <= head_job.j_first;
		end else if (produce && !done) begin
			j_q <= j_q - 1'b1;
		end
		if (produce) begin
			val_q  <= job_q.vals[j_q];
			last_q <= job_q.flush && (j_q == '0);
		end
	end

	a_plain_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !job_q.flush) |-> (j_q == job_q.j_first))
		else $error("plain job index moved");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (j_q <= job_q.j_first))
		else $error("result index above the job's first index");

	a_plain_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && !job_q.flush) |=> !last_q)
		else $error("end-of-line mark on a mid-line result");

endmodule

// ===== rtl/centered_moving_max_filter.sv =====
// Top level of the centered moving-maximum filter.
//
// Input channel: sample and last_in move on a transaction when in_valid is high and
// in_stall is low; last_in marks the final sample of a line. Output channel:
// filtered_value and last_out move when out_valid is high and out_stall is low.
// win_half is written when win_half_we is high; values above 16 act as 16.
// A mid-line result belongs to the sample win_half places back. The final sample of
// a line releases the remaining results of that line as a run, the last one marked.
// A result passes through the six registered prefix-maximum levels over the 33-entry
// window, the queue, the back end's job register and the output register. Throughput:
// one sample per cycle on the input while in_stall is low; the back end puts out one
// result per cycle while out_stall is low; a flush run of n results keeps it busy while
// the two-entry job queue lets the front end keep taking samples.
// Reset: win_half returns to 7, the line count is cleared and all pipelines and the
// queue empty. When the receiver stalls, the result holds in the output register, jobs
// gather in the queue, and in_stall rises once the queue and the tree's tail are full.
module centered_moving_max_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cmm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                            last_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cmm_pkg::SAMPLE_BITS-1:0] filtered_value,
	output logic                            last_out,
	input  logic                            win_half_we,
	input  logic [cmm_pkg::HALF_REG_W-1:0]  win_half
);

	cmm_pkg::cmm_qstat_t q_stat;
	cmm_pkg::cmm_job_t   push_job;
	cmm_pkg::cmm_job_t   head_job;
	logic                push;
	logic                pop;

	cmm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.last_in     (last_in),
		.win_half_we (win_half_we),
		.win_half    (win_half),
		.q_stat      (q_stat),
		.push        (push),
		.push_job    (push_job)
	);

	cmm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	cmm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_stat         (q_stat),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_value (filtered_value),
		.last_out       (last_out)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the centered moving-maximum filter.
`timescale 1ns / 1ps

module testbench;

	localparam int DRAIN_SLACK  = 16;
	localparam int RANDOM_ITEMS = 400;

	// Scoreboard: its own copy of the window line, line count and half-window register.
	class peak_scoreboard;
		typedef struct packed {
			logic [cmm_pkg::SAMPLE_BITS-1:0] value;
			logic                            last;
		} peak_t;

		logic [cmm_pkg::SAMPLE_BITS-1:0] line_buf [cmm_pkg::DEPTH];
		bit                              line_ok [cmm_pkg::DEPTH];
		int unsigned                     line_count;
		logic [cmm_pkg::HALF_REG_W-1:0]  half_reg;
		peak_t                           expected_peaks [$];
		int                              errors;

		function new();
			foreach (line_buf[k]) begin
				line_buf[k] = '0;
				line_ok[k]  = 1'b0;
			end
			line_count = 0;
			half_reg   = cmm_pkg::HALF_RESET;
			errors     = 0;
		endfunction

		function void set_half(logic [cmm_pkg::HALF_REG_W-1:0] v);
			half_reg = v;
		endfunction

		function int pending();
			return expected_peaks.size();
		endfunction

		// Maximum for the position whose sample sits at offset d of the line buffer.
		function logic [cmm_pkg::SAMPLE_BITS-1:0] window_peak(int d, int h);
			logic [cmm_pkg::SAMPLE_BITS-1:0] best;
			int lo;
			int hi;
			best = '0;
			lo   = (d >= h) ? d - h : 0;
			hi   = (d + h > cmm_pkg::DEPTH - 1) ? cmm_pkg::DEPTH - 1 : d + h;
			for (int k = lo; k <= hi; k++) begin
				if (line_ok[k] && line_buf[k] > best)
					best = line_buf[k];
			end
			return best;
		endfunction

		function void note_sample(logic [cmm_pkg::SAMPLE_BITS-1:0] s, logic last);
			int    h;
			int    d;
			peak_t p;
			h = (half_reg > cmm_pkg::MAX_HALF) ? cmm_pkg::MAX_HALF : int'(half_reg);
			for (int k = cmm_pkg::DEPTH - 1; k > 0; k--) begin
				line_buf[k] = line_buf[k-1];
				line_ok[k]  = line_ok[k-1];
			end
			line_buf[0] = s;
			line_ok[0]  = 1'b1;
			if (line_count < 31)
				line_count++;
			if (!last) begin
				if (line_count > h) begin
					p.value = window_peak(h, h);
					p.last  = 1'b0;
					expected_peaks = {expected_peaks, p};
				end
			end else begin
				// Flush the pending positions, oldest first; mark the newest.
				d = (int'(line_count) - 1 < h) ? int'(line_count) - 1 : h;
				for (int j = d; j >= 0; j--) begin
					p.value = window_peak(j, h);
					p.last  = (j == 0);
					expected_peaks = {expected_peaks, p};
				end
				foreach (line_ok[k])
					line_ok[k] = 1'b0;
				line_count = 0;
			end
		endfunction

		function void check_peak(logic [cmm_pkg::SAMPLE_BITS-1:0] value, logic last);
			peak_t p;
			if (expected_peaks.size() == 0) begin
				$error("unexpected result: filtered_value=%0d last_out=%0b", value, last);
				errors++;
				return;
			end
			p = expected_peaks.pop_front();
			if (value !== p.value) begin
				$error("filtered_value: expected %0d, actual %0d", p.value, value);
				errors++;
			end
			if (last !== p.last) begin
				$error("last_out: expected %0b, actual %0b", p.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic [cmm_pkg::SAMPLE_BITS-1:0] sample      = '0;
	logic                            last_in     = 1'b0;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [cmm_pkg::SAMPLE_BITS-1:0] filtered_value;
	logic                            last_out;
	logic                            win_half_we = 1'b0;
	logic [cmm_pkg::HALF_REG_W-1:0]  win_half    = '0;

	peak_scoreboard sb = new();
	bit             steady = 1'b0;
	int             sent   = 0;

	centered_moving_max_filter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.last_in        (last_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_value (filtered_value),
		.last_out       (last_out),
		.win_half_we    (win_half_we),
		.win_half       (win_half)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_peak(filtered_value, last_out);
	end

	// Receiver: stall a random number of cycles before each transaction.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = steady ? 0 : int'($urandom_range(0, 13));
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic push_sample(logic [cmm_pkg::SAMPLE_BITS-1:0] s, logic last);
		int gap;
		gap = steady ? 0 : int'($urandom_range(0, 13));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		last_in  <= last;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s, last);
		sent++;
	endtask

	// Hold the sender until every expected result has come, then let the pipeline drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic load_half(logic [cmm_pkg::HALF_REG_W-1:0] v);
		win_half_we <= 1'b1;
		win_half    <= v;
		@(posedge clk);
		win_half_we <= 1'b0;
		sb.set_half(v);
	endtask

	function automatic logic [cmm_pkg::SAMPLE_BITS-1:0] shaped_sample(int shape, int idx,
			int base);
		case (shape)
			0: return cmm_pkg::SAMPLE_BITS'($urandom_range(0, 255));
			1: return cmm_pkg::SAMPLE_BITS'(base + idx * 7);
			2: return cmm_pkg::SAMPLE_BITS'(base - idx * 5);
			3: return ($urandom_range(0, 7) == 0) ?
				cmm_pkg::SAMPLE_BITS'($urandom_range(0, 255)) : '0;
			default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
		endcase
	endfunction

	task automatic random_half();
		case ($urandom_range(0, 5))
			0: load_half('0);
			1: load_half(cmm_pkg::HALF_REG_W'(cmm_pkg::MAX_HALF));
			2: load_half('1);
			default: load_half(cmm_pkg::HALF_REG_W'($urandom_range(0, 31)));
		endcase
	endtask

	initial begin
		int len;
		int shape;
		int base;
		int split;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset half window of 7 over a line shorter than the window.
		push_sample(8'h00, 1'b0);
		push_sample(8'hFF, 1'b0);
		push_sample(8'h55, 1'b0);
		push_sample(8'hAA, 1'b0);
		push_sample(8'h01, 1'b1);
		settle();
		// Zero half window: each sample comes straight back.
		load_half('0);
		push_sample(8'h00, 1'b0);
		push_sample(8'hFF, 1'b1);
		settle();
		// Oversized half window saturates; short line and single-sample line.
		load_half('1);
		push_sample(8'hFF, 1'b0);
		push_sample(8'h00, 1'b0);
		push_sample(8'h80, 1'b1);
		push_sample(8'hAA, 1'b1);
		settle();
		load_half(cmm_pkg::HALF_REG_W'(1));
		push_sample(8'h55, 1'b0);
		push_sample(8'hFF, 1'b0);
		push_sample(8'h00, 1'b0);
		push_sample(8'h01, 1'b1);
		settle();
		// Change the half window in the middle of a line.
		load_half(cmm_pkg::HALF_REG_W'(2));
		push_sample(8'h10, 1'b0);
		push_sample(8'h90, 1'b0);
		push_sample(8'h20, 1'b0);
		settle();
		load_half(cmm_pkg::HALF_REG_W'(5));
		push_sample(8'h30, 1'b0);
		push_sample(8'h05, 1'b0);
		push_sample(8'h40, 1'b1);
		settle();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				settle();
				random_half();
			end
			steady = ($urandom_range(0, 4) == 0);
			len    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(32, 45))
			                                      : int'($urandom_range(1, 20));
			shape  = int'($urandom_range(0, 4));
			base   = int'($urandom_range(0, 255));
			split  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, len)) : 0;
			for (int i = 0; i < len; i++) begin
				if (split != 0 && i == split) begin
					settle();
					random_half();
				end
				push_sample(shaped_sample(shape, i, base), i == len - 1);
			end
		end

		steady = 1'b0;
		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
